@@ hdl/depth_gated_three_frame_motion_mask_core_assert.svh @@
// Assertion macros for the motion mask core.
// Included by the modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef DEPTH_GATED_THREE_FRAME_MOTION_MASK_CORE_ASSERT_SVH
`define DEPTH_GATED_THREE_FRAME_MOTION_MASK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// checked on every edge outside reset
`define MMASK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define MMASK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MMASK_ASSERT(lbl, prop, msg)
`define MMASK_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hdl/mmask_pkg.sv @@
// Shared types, constants and the gray conversion for the motion mask core.
// No dependencies; the interfaces and modules refer to it by scoped names.
`timescale 1ns / 1ps
package mmask_pkg;

    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;
    localparam int PIXELS       = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W       = $clog2(PIXELS);
    localparam int DIM_W        = 13;

    localparam int PIX_W   = 8;
    localparam int DEPTH_W = 14;
    localparam int ROW_W   = 9;
    localparam int COL_W   = 10;
    localparam int THR_W   = 8;

    localparam int FRAMES_W = 2;
    localparam logic [FRAMES_W-1:0] FRAMES_ONE  = 2'd1;
    localparam logic [FRAMES_W-1:0] FRAMES_FULL = 2'd2;

    // store word: previous motion bit over previous gray
    localparam int STORE_W = PIX_W + 1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZON_ROW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_ROWS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_COLS      = 3'd5;

    localparam logic [DEPTH_W-1:0] RST_MIN_DEPTH      = 14'd0;
    localparam logic [DEPTH_W-1:0] RST_MAX_DEPTH      = 14'd2000;
    localparam logic [THR_W-1:0]   RST_DIFF_THRESHOLD = 8'd10;
    localparam logic [ROW_W-1:0]   RST_HORIZON_ROW    = 9'd120;
    localparam logic [ROW_W-1:0]   RST_GATE_ROWS      = 9'd240;
    localparam logic [COL_W-1:0]   RST_GATE_COLS      = 10'd320;

    // 14-bit luma weights with rounding
    localparam int GRAY_SUM_W = 22;
    localparam int GRAY_SHIFT = 14;
    localparam logic [GRAY_SUM_W-1:0] W_RED   = 22'd4899;
    localparam logic [GRAY_SUM_W-1:0] W_GREEN = 22'd9617;
    localparam logic [GRAY_SUM_W-1:0] W_BLUE  = 22'd1868;
    localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = 22'd8192;

    typedef struct packed {
        logic [DEPTH_W-1:0] min_depth;
        logic [DEPTH_W-1:0] max_depth;
        logic [THR_W-1:0]   diff_threshold;
        logic [ROW_W-1:0]   horizon_row;
        logic [ROW_W-1:0]   gate_rows;
        logic [COL_W-1:0]   gate_cols;
    } cfg_t;

    // classified pixel handed from front to back
    typedef struct packed {
        logic [PIX_W-1:0]    gray;
        logic [ADDR_W-1:0]   addr;
        logic                in_frame;
        logic [FRAMES_W-1:0] frames;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0] gray_value;
        logic             motion_now;
        logic             foreground;
        logic             foreground_valid;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [PIX_W-1:0] gray_of(
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] g,
        input logic [PIX_W-1:0] r
    );
        logic [GRAY_SUM_W-1:0] sum;
        sum = GRAY_SUM_W'(r) * W_RED + GRAY_SUM_W'(g) * W_GREEN
            + GRAY_SUM_W'(b) * W_BLUE + GRAY_ROUND;
        return sum[GRAY_SHIFT +: PIX_W];
    endfunction

endpackage

@@ hdl/mmask_if.sv @@
// Channel interfaces of the motion mask core: pixel in, result out, register write.
// Depends on mmask_pkg for field widths.
`timescale 1ns / 1ps
interface mmask_pix_if;
    logic                            valid;
    logic                            ready;
    logic [mmask_pkg::PIX_W-1:0]     blue;
    logic [mmask_pkg::PIX_W-1:0]     green;
    logic [mmask_pkg::PIX_W-1:0]     red;
    logic [mmask_pkg::DEPTH_W-1:0]   depth;
    logic [mmask_pkg::ROW_W-1:0]     row;
    logic [mmask_pkg::COL_W-1:0]     col;
    logic                            end_of_frame;

    modport source (output valid, blue, green, red, depth, row, col, end_of_frame,
                    input ready);
    modport sink (input valid, blue, green, red, depth, row, col, end_of_frame,
                  output ready);
endinterface

interface mmask_res_if;
    logic                        valid;
    logic                        ready;
    logic [mmask_pkg::PIX_W-1:0] gray_value;
    logic                        motion_now;
    logic                        foreground;
    logic                        foreground_valid;

    modport source (output valid, gray_value, motion_now, foreground, foreground_valid,
                    input ready);
    modport sink (input valid, gray_value, motion_now, foreground, foreground_valid,
                  output ready);
endinterface

interface mmask_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mmask_pkg::CFG_IDX_W-1:0]   index;
    logic [mmask_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/depth_gated_three_frame_motion_mask_core.sv @@
// Depth-gated three-frame motion mask: top level with configuration registers.
// Depends on mmask_pkg, mmask_if, mmask_front, mmask_queue and mmask_back.
//
// Channels: pix takes one pixel per item (colour bytes, depth, row, col,
// end_of_frame); res returns one result per pixel (gray_value, motion_now,
// foreground, foreground_valid); cfg writes one register per item, index
// 0..5 = min_depth, max_depth, diff_threshold, horizon_row, gate_rows,
// gate_cols; cfg is always ready and other indexes are ignored.
// Throughput: one pixel per cycle while res is ready, set by the frame
// store in the back part, which takes one read and one write each cycle
// (separate ports). Path: a pixel passes the front register, the queue,
// the store read stage and the output register before its result is valid.
// Reset: registers take their defaults, the frame counter and all pipeline
// valids clear; the frame store holds whatever it held and is rewritten by
// the first frame, so no clearing pass is run.
// Stalls: while res is held off, the result stays in the output register;
// up to the queue depth plus two further pixels are taken before pix
// ready drops.
`timescale 1ns / 1ps
module depth_gated_three_frame_motion_mask_core (
    input  logic        clk,
    input  logic        rst_n,
    mmask_pix_if.sink   pix,
    mmask_res_if.source res,
    mmask_cfg_if.sink   cfg
);

    mmask_pkg::cfg_t       cfg_reg;
    mmask_pkg::item_t      push_item;
    mmask_pkg::item_t      head;
    mmask_pkg::q_status_t  q_st;
    logic                  push;
    logic                  pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_depth      <= mmask_pkg::RST_MIN_DEPTH;
            cfg_reg.max_depth      <= mmask_pkg::RST_MAX_DEPTH;
            cfg_reg.diff_threshold <= mmask_pkg::RST_DIFF_THRESHOLD;
            cfg_reg.horizon_row    <= mmask_pkg::RST_HORIZON_ROW;
            cfg_reg.gate_rows      <= mmask_pkg::RST_GATE_ROWS;
            cfg_reg.gate_cols      <= mmask_pkg::RST_GATE_COLS;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                mmask_pkg::REG_MIN_DEPTH:
                    cfg_reg.min_depth <= cfg.data[mmask_pkg::DEPTH_W-1:0];
                mmask_pkg::REG_MAX_DEPTH:
                    cfg_reg.max_depth <= cfg.data[mmask_pkg::DEPTH_W-1:0];
                mmask_pkg::REG_DIFF_THRESHOLD:
                    cfg_reg.diff_threshold <= cfg.data[mmask_pkg::THR_W-1:0];
                mmask_pkg::REG_HORIZON_ROW:
                    cfg_reg.horizon_row <= cfg.data[mmask_pkg::ROW_W-1:0];
                mmask_pkg::REG_GATE_ROWS:
                    cfg_reg.gate_rows <= cfg.data[mmask_pkg::ROW_W-1:0];
                mmask_pkg::REG_GATE_COLS:
                    cfg_reg.gate_cols <= cfg.data[mmask_pkg::COL_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    mmask_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .cfg       (cfg_reg),
        .q_st      (q_st),
        .push      (push),
        .push_item (push_item)
    );

    mmask_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .st        (q_st)
    );

    mmask_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .q_st           (q_st),
        .diff_threshold (cfg_reg.diff_threshold),
        .pop            (pop),
        .res            (res)
    );

endmodule

@@ hdl/mmask_front.sv @@
// Front part: accepts pixels, applies the depth gate, forms gray and store address, counts frames.
// Depends on mmask_pkg and mmask_pix_if; feeds mmask_queue.
`timescale 1ns / 1ps
module mmask_front (
    input  logic                  clk,
    input  logic                  rst_n,
    mmask_pix_if.sink             pix,
    input  mmask_pkg::cfg_t       cfg,
    input  mmask_pkg::q_status_t  q_st,
    output logic                  push,
    output mmask_pkg::item_t      push_item
);

    logic                               f_valid_reg;
    logic                               f_valid_next;
    mmask_pkg::item_t                   f_item_reg;
    logic [mmask_pkg::FRAMES_W-1:0]     frames_reg;
    logic [mmask_pkg::FRAMES_W-1:0]     frames_next;

    logic             acc;
    logic             gated;
    logic             black;
    logic             in_frame;
    mmask_pkg::item_t item_c;

    assign push      = f_valid_reg && !q_st.full;
    assign push_item = f_item_reg;
    assign pix.ready = !f_valid_reg || !q_st.full;
    assign acc       = pix.valid && pix.ready;

    always_comb
    begin
        gated = (pix.row < cfg.gate_rows) && (pix.col < cfg.gate_cols);
        black = gated && ((pix.depth == '0) || (pix.depth < cfg.min_depth)
                || (pix.depth > cfg.max_depth) || (pix.row >= cfg.horizon_row));
        in_frame = (mmask_pkg::DIM_W'(pix.row) < mmask_pkg::DIM_W'(mmask_pkg::FRAME_HEIGHT))
                && (mmask_pkg::DIM_W'(pix.col) < mmask_pkg::DIM_W'(mmask_pkg::FRAME_WIDTH));
        item_c.gray     = black ? '0 : mmask_pkg::gray_of(pix.blue, pix.green, pix.red);
        item_c.addr     = mmask_pkg::ADDR_W'(pix.row)
                        * mmask_pkg::ADDR_W'(mmask_pkg::FRAME_WIDTH)
                        + mmask_pkg::ADDR_W'(pix.col);
        item_c.in_frame = in_frame;
        item_c.frames   = frames_reg;
    end

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (acc)
        begin
            f_valid_next = 1'b1;
        end
        else if (push)
        begin
            f_valid_next = 1'b0;
        end
        frames_next = frames_reg;
        if (acc && pix.end_of_frame && (frames_reg != mmask_pkg::FRAMES_FULL))
        begin
            frames_next = frames_reg + mmask_pkg::FRAMES_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            frames_reg  <= '0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
            frames_reg  <= frames_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            f_item_reg <= item_c;
        end
    end

endmodule

@@ hdl/mmask_queue.sv @@
// Short item queue between the front and back parts.
// Depends on mmask_pkg and the assertion header.
`timescale 1ns / 1ps
`include "depth_gated_three_frame_motion_mask_core_assert.svh"
module mmask_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mmask_pkg::item_t      push_item,
    input  logic                  pop,
    output mmask_pkg::item_t      head,
    output mmask_pkg::q_status_t  st
);

    mmask_pkg::item_t                entries_reg [mmask_pkg::Q_DEPTH];
    logic [mmask_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [mmask_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [mmask_pkg::Q_CNT_W-1:0]   count_reg;
    logic [mmask_pkg::Q_CNT_W-1:0]   count_next;

    assign head     = entries_reg[rd_ptr_reg];
    assign st.full  = (count_reg == mmask_pkg::Q_CNT_W'(mmask_pkg::Q_DEPTH));
    assign st.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    `MMASK_ASSERT(a_q_no_overflow, push |-> !st.full, "item pushed into full queue")
    `MMASK_ASSERT(a_q_no_underflow, pop |-> !st.empty, "item popped from empty queue")
    `MMASK_ASSERT_ALWAYS(a_q_reset_empty, !rst_n |-> (count_reg == '0), "queue not empty in reset")

endmodule

@@ hdl/mmask_back.sv @@
// Back part: frame store read-modify-write, frame difference, motion and foreground.
// Depends on mmask_pkg, mmask_res_if and the assertion header.
`timescale 1ns / 1ps
`include "depth_gated_three_frame_motion_mask_core_assert.svh"
module mmask_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mmask_pkg::item_t              head,
    input  mmask_pkg::q_status_t          q_st,
    input  logic [mmask_pkg::THR_W-1:0]   diff_threshold,
    output logic                          pop,
    mmask_res_if.source                   res
);

    // frame store: {previous motion, previous gray} per pixel
    logic [mmask_pkg::STORE_W-1:0] store_mem [mmask_pkg::PIXELS];

    logic [mmask_pkg::STORE_W-1:0] mem_q_reg;
    logic [mmask_pkg::STORE_W-1:0] byp_data_reg;
    logic                          byp_sel_reg;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    mmask_pkg::item_t              s1_item_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    mmask_pkg::result_t            out_reg;

    logic                          s1_adv;
    logic                          wr_en;
    logic [mmask_pkg::STORE_W-1:0] wr_data;
    logic [mmask_pkg::STORE_W-1:0] prev;
    logic [mmask_pkg::PIX_W-1:0]   diff;
    logic                          motion;
    logic                          have_prev;
    logic                          full_hist;
    mmask_pkg::result_t            res_c;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || res.ready);
    assign pop    = !q_st.empty && (!s1_valid_reg || s1_adv);

    always_comb
    begin
        prev      = byp_sel_reg ? byp_data_reg : mem_q_reg;
        diff      = (s1_item_reg.gray > prev[mmask_pkg::PIX_W-1:0])
                  ? s1_item_reg.gray - prev[mmask_pkg::PIX_W-1:0] : '0;
        have_prev = (s1_item_reg.frames >= mmask_pkg::FRAMES_ONE);
        full_hist = (s1_item_reg.frames >= mmask_pkg::FRAMES_FULL);
        motion    = s1_item_reg.in_frame && have_prev && (diff >= diff_threshold);
        wr_en     = s1_adv && s1_item_reg.in_frame;
        wr_data   = {motion, s1_item_reg.gray};

        res_c.gray_value       = s1_item_reg.gray;
        res_c.motion_now       = motion;
        res_c.foreground       = full_hist && motion && prev[mmask_pkg::PIX_W];
        res_c.foreground_valid = full_hist;

        s1_valid_next = s1_valid_reg;
        if (pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[s1_item_reg.addr] <= wr_data;
        end
        if (pop && head.in_frame)
        begin
            mem_q_reg <= store_mem[head.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_sel_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                // read in the same cycle as the write to that pixel returns stale data
                byp_sel_reg <= wr_en && (s1_item_reg.addr == head.addr);
            end
            else if (s1_adv)
            begin
                byp_sel_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_item_reg  <= head;
            byp_data_reg <= wr_data;
        end
        if (s1_adv)
        begin
            out_reg <= res_c;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.gray_value       = out_reg.gray_value;
    assign res.motion_now       = out_reg.motion_now;
    assign res.foreground       = out_reg.foreground;
    assign res.foreground_valid = out_reg.foreground_valid;

    `MMASK_ASSERT(a_fg_needs_motion, (out_valid_reg && out_reg.foreground) |-> (out_reg.motion_now && out_reg.foreground_valid), "foreground without motion or history")
    `MMASK_ASSERT(a_stall_holds_read, (s1_valid_reg && !s1_adv) |=> ($stable(mem_q_reg) && $stable(byp_sel_reg)), "store read data lost during stall")
    `MMASK_ASSERT(a_bypass_owner, byp_sel_reg |-> s1_valid_reg, "bypass selected with empty stage")

endmodule
